/* rtl/csv_record_tokenizer_defines.svh */
// ----------------------------------------------------------------------------
// csv_record_tokenizer_defines.svh
// Assertion macros used by the CSV tokenizer top module.
// ----------------------------------------------------------------------------
`ifndef CSV_RECORD_TOKENIZER_DEFINES_SVH
`define CSV_RECORD_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CSVTOK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csvtok: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define CSVTOK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csvtok: next-cycle check failed");

`endif

/* rtl/csvtok_pkg.sv */
// ----------------------------------------------------------------------------
// csvtok_pkg
// Types and character constants for the CSV record tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package csvtok_pkg;

  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChQuote = 8'h22;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_FIELD  = 2'd1,
    KIND_RECORD = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [0:0] {
    ERR_MISPLACED_QUOTE = 1'b0,
    ERR_UNCLOSED_QUOTE  = 1'b1
  } err_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    err_e       error_code;
  } out_word_t;

  typedef struct packed {
    logic inside_quotes;
    logic quote_pending;
    logic after_closing_quote;
    logic field_has_content;
    logic record_has_data;
    logic after_carriage_return;
    logic failed;
  } tok_state_t;

endpackage

`default_nettype wire

/* rtl/csv_record_tokenizer.sv */
// ----------------------------------------------------------------------------
// csv_record_tokenizer
// Streaming CSV tokenizer: bytes in, data bytes and field/record marks out.
// ----------------------------------------------------------------------------
// The tokenizer takes one word per cycle unless stalled, either a text byte
// or an end-of-stream mark, and returns at most one word per input: a
// content byte, a field end, a field-and-record end, or an error. Quoted
// fields, doubled quotes, CR, LF and CRLF line ends are handled. Throughput
// is one input word per clock while the result register can take results,
// set by the combinational state update in the step logic between the input
// register and the result register. After an error all bytes are dropped
// until end of stream, which returns the block to its reset state.
`default_nettype none
`include "csv_record_tokenizer_defines.svh"

module csv_record_tokenizer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  csvtok_pkg::in_word_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output csvtok_pkg::out_word_t out_data_o
);

  // input register
  logic                   in_valid_q;
  logic                   in_valid_d;
  csvtok_pkg::in_word_t   in_q;

  // tokenizer state
  csvtok_pkg::tok_state_t st_q;
  csvtok_pkg::tok_state_t st_d;

  logic                   res_valid;
  csvtok_pkg::out_word_t  res;
  logic                   out_ready;
  logic                   advance;
  logic                   in_accept;

  csvtok_step u_step (
    .st_i        (st_q),
    .word_i      (in_q),
    .st_o        (st_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // held word moves on if it has no result or the result register is free
  assign advance    = in_valid_q && (!res_valid || out_ready);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = in_accept ? 1'b1 : (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      st_q       <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (advance) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  csvtok_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .load_data_i (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // a pending quote only exists inside a quoted field
  `CSVTOK_ASSERT_NOW(a_pend_in_quotes, st_q.quote_pending, st_q.inside_quotes)
  // errors are raised outside quotes only
  `CSVTOK_ASSERT_NOW(a_failed_unquoted, st_q.failed, !st_q.inside_quotes && !st_q.quote_pending)
  // only data words carry a byte
  `CSVTOK_ASSERT_NOW(a_byte_only_data, out_valid_o && (out_data_o.kind != csvtok_pkg::KIND_DATA),
                     out_data_o.out_byte == 8'h00)
  // only error words carry a nonzero code
  `CSVTOK_ASSERT_NOW(a_code_only_error, out_valid_o && (out_data_o.kind != csvtok_pkg::KIND_ERROR),
                     out_data_o.error_code == csvtok_pkg::ERR_MISPLACED_QUOTE)
  // end of stream leaves the reset state
  `CSVTOK_ASSERT_NEXT(a_eos_clears, advance && in_q.end_of_stream, st_q == '0)

endmodule

`default_nettype wire

/* rtl/csvtok_step.sv */
// ----------------------------------------------------------------------------
// csvtok_step
// Combinational tokenizer step: state and one input word in, next state and
// at most one result word out.
// ----------------------------------------------------------------------------
`default_nettype none

module csvtok_step (
  input  csvtok_pkg::tok_state_t st_i,
  input  csvtok_pkg::in_word_t   word_i,
  output csvtok_pkg::tok_state_t st_o,
  output logic                   res_valid_o,
  output csvtok_pkg::out_word_t  res_o
);

  logic       iq;
  logic       acq;
  logic       is_quote;
  logic       is_delim;
  logic [7:0] c;

  assign c        = word_i.in_byte;
  assign is_quote = (c == csvtok_pkg::ChQuote);
  assign is_delim = (c == csvtok_pkg::ChComma) || (c == csvtok_pkg::ChLf) ||
                    (c == csvtok_pkg::ChCr);

  always_comb begin
    st_o             = st_i;
    res_valid_o      = 1'b0;
    res_o.out_byte   = 8'h00;
    res_o.kind       = csvtok_pkg::KIND_DATA;
    res_o.error_code = csvtok_pkg::ERR_MISPLACED_QUOTE;
    iq               = st_i.inside_quotes;
    acq              = st_i.after_closing_quote;

    if (word_i.end_of_stream) begin
      st_o = '0;
      if (!st_i.failed) begin
        // a pending quote closes the field
        if (st_i.inside_quotes && !st_i.quote_pending) begin
          res_valid_o      = 1'b1;
          res_o.kind       = csvtok_pkg::KIND_ERROR;
          res_o.error_code = csvtok_pkg::ERR_UNCLOSED_QUOTE;
        end else if (st_i.record_has_data) begin
          res_valid_o = 1'b1;
          res_o.kind  = csvtok_pkg::KIND_RECORD;
        end
      end
    end else if (!st_i.failed) begin
      st_o.after_carriage_return = 1'b0;
      if (st_i.after_carriage_return && (c == csvtok_pkg::ChLf)) begin
        // LF of a CRLF pair: swallowed
      end else if (st_i.quote_pending && is_quote) begin
        // doubled quote: literal quote
        st_o.quote_pending     = 1'b0;
        st_o.field_has_content = 1'b1;
        res_valid_o            = 1'b1;
        res_o.out_byte         = csvtok_pkg::ChQuote;
      end else begin
        if (st_i.quote_pending) begin
          iq  = 1'b0;
          acq = 1'b1;
        end
        st_o.quote_pending       = 1'b0;
        st_o.record_has_data     = 1'b1;
        st_o.inside_quotes       = iq;
        st_o.after_closing_quote = acq;
        if (iq) begin
          if (is_quote) begin
            st_o.quote_pending = 1'b1;
          end else begin
            st_o.field_has_content = 1'b1;
            res_valid_o            = 1'b1;
            res_o.out_byte         = c;
          end
        end else if (is_delim) begin
          st_o.field_has_content   = 1'b0;
          st_o.after_closing_quote = 1'b0;
          res_valid_o              = 1'b1;
          if (c == csvtok_pkg::ChComma) begin
            res_o.kind = csvtok_pkg::KIND_FIELD;
          end else begin
            res_o.kind                 = csvtok_pkg::KIND_RECORD;
            st_o.record_has_data       = 1'b0;
            st_o.after_carriage_return = (c == csvtok_pkg::ChCr);
          end
        end else if (is_quote && !st_i.field_has_content && !acq) begin
          st_o.inside_quotes = 1'b1;
        end else if (acq || is_quote) begin
          st_o.failed = 1'b1;
          res_valid_o = 1'b1;
          res_o.kind  = csvtok_pkg::KIND_ERROR;
        end else begin
          st_o.field_has_content = 1'b1;
          res_valid_o            = 1'b1;
          res_o.out_byte         = c;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/csvtok_out_stage.sv */
// ----------------------------------------------------------------------------
// csvtok_out_stage
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module csvtok_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  csvtok_pkg::out_word_t load_data_i,
  output logic                  ready_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output csvtok_pkg::out_word_t out_data_o
);

  logic                  valid_q;
  logic                  valid_d;
  csvtok_pkg::out_word_t data_q;

  // free when empty or the held word leaves this cycle
  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= load_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

/* test/csv_record_tokenizer_test.sv */
// ----------------------------------------------------------------------------
// csv_record_tokenizer_test
// Self-checking bench for the streaming CSV tokenizer.
// ----------------------------------------------------------------------------
// A driver streams CSV text words from a queue: first a short directed set,
// then random streams. Most of these are well-formed records with random
// field content, and the rest are noise or broken quoting. A monitor runs
// its own tokenizer model on every accepted input word and compares each
// result word with the oldest expected token. Both sides idle at random.
// The receiver also holds off once for a long stretch, and the sender
// pauses now and then until every expected token has come back.
module csv_record_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 100000;
  localparam int TextWords   = 1250;
  localparam int HoldAt      = 150;   // results seen before the long hold-off
  localparam int HoldCycles  = 300;
  localparam int CalmFrom    = 600;   // window with no idling on either side
  localparam int CalmTo      = 1400;
  localparam int DrainCycles = 20;    // margin for words still in the block

  typedef struct {
    csvtok_pkg::in_word_t w;
    bit                   drain;   // sender waits for all tokens before offering this one
  } feed_t;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  csvtok_pkg::in_word_t  in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  csvtok_pkg::out_word_t out_data_o;

  feed_t                  text_q[$];     // text words not yet accepted; front is on the bus
  csvtok_pkg::out_word_t  token_q[$];    // tokens expected from the block, oldest first
  csvtok_pkg::tok_state_t parse_st = '0;

  int  cycle_cnt    = 0;
  int  text_count   = 0;
  int  words_in     = 0;
  int  results_seen = 0;
  int  records_seen = 0;
  int  errors_seen  = 0;
  int  mismatches   = 0;
  int  hold_left    = 0;
  bit  held         = 1'b0;
  bit  drain_next   = 1'b0;
  logic drained     = 1'b1;
  logic calm;

  assign calm = (cycle_cnt >= CalmFrom) && (cycle_cnt < CalmTo);

  csv_record_tokenizer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // Tokenizer model
  // --------------------------------------------------------------------------
  function automatic csvtok_pkg::out_word_t make_token(logic [7:0] b,
                                                       csvtok_pkg::kind_e k,
                                                       csvtok_pkg::err_e e);
    csvtok_pkg::out_word_t t;
    t.out_byte   = b;
    t.kind       = k;
    t.error_code = e;
    return t;
  endfunction

  // Advances parse_st by one text word; returns 1 when a token comes out.
  function automatic bit tokenize(input csvtok_pkg::in_word_t w,
                                  output csvtok_pkg::out_word_t tok);
    logic [7:0] c;
    c   = w.in_byte;
    tok = make_token(8'h00, csvtok_pkg::KIND_DATA, csvtok_pkg::ERR_MISPLACED_QUOTE);

    if (w.end_of_stream) begin
      bit hit;
      hit = 1'b0;
      if (!parse_st.failed) begin
        // a quote still waiting for its partner closes the field here
        if (parse_st.quote_pending) parse_st.inside_quotes = 1'b0;
        if (parse_st.inside_quotes) begin
          tok = make_token(8'h00, csvtok_pkg::KIND_ERROR, csvtok_pkg::ERR_UNCLOSED_QUOTE);
          hit = 1'b1;
        end else if (parse_st.record_has_data) begin
          tok = make_token(8'h00, csvtok_pkg::KIND_RECORD, csvtok_pkg::ERR_MISPLACED_QUOTE);
          hit = 1'b1;
        end
      end
      parse_st = '0;
      return hit;
    end

    if (parse_st.failed) return 1'b0;

    // LF right after a CR record end is part of the same line break
    if (parse_st.after_carriage_return) begin
      parse_st.after_carriage_return = 1'b0;
      if (c == csvtok_pkg::ChLf) return 1'b0;
    end

    if (parse_st.quote_pending) begin
      parse_st.quote_pending = 1'b0;
      if (c == csvtok_pkg::ChQuote) begin
        parse_st.field_has_content = 1'b1;
        tok = make_token(csvtok_pkg::ChQuote, csvtok_pkg::KIND_DATA,
                         csvtok_pkg::ERR_MISPLACED_QUOTE);
        return 1'b1;
      end
      parse_st.inside_quotes       = 1'b0;
      parse_st.after_closing_quote = 1'b1;
    end

    parse_st.record_has_data = 1'b1;

    if (parse_st.inside_quotes) begin
      if (c == csvtok_pkg::ChQuote) begin
        parse_st.quote_pending = 1'b1;
        return 1'b0;
      end
      parse_st.field_has_content = 1'b1;
      tok = make_token(c, csvtok_pkg::KIND_DATA, csvtok_pkg::ERR_MISPLACED_QUOTE);
      return 1'b1;
    end

    if (c == csvtok_pkg::ChComma || c == csvtok_pkg::ChLf || c == csvtok_pkg::ChCr) begin
      parse_st.field_has_content   = 1'b0;
      parse_st.after_closing_quote = 1'b0;
      if (c == csvtok_pkg::ChComma) begin
        tok = make_token(8'h00, csvtok_pkg::KIND_FIELD, csvtok_pkg::ERR_MISPLACED_QUOTE);
        return 1'b1;
      end
      parse_st.record_has_data       = 1'b0;
      parse_st.after_carriage_return = (c == csvtok_pkg::ChCr);
      tok = make_token(8'h00, csvtok_pkg::KIND_RECORD, csvtok_pkg::ERR_MISPLACED_QUOTE);
      return 1'b1;
    end

    if (c == csvtok_pkg::ChQuote && !parse_st.field_has_content &&
        !parse_st.after_closing_quote) begin
      parse_st.inside_quotes = 1'b1;
      return 1'b0;
    end

    if (parse_st.after_closing_quote || c == csvtok_pkg::ChQuote) begin
      parse_st.failed = 1'b1;
      tok = make_token(8'h00, csvtok_pkg::KIND_ERROR, csvtok_pkg::ERR_MISPLACED_QUOTE);
      return 1'b1;
    end

    parse_st.field_has_content = 1'b1;
    tok = make_token(c, csvtok_pkg::KIND_DATA, csvtok_pkg::ERR_MISPLACED_QUOTE);
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  // counted = 0 marks bytes that a failed stream just drops
  function automatic void put_word(csvtok_pkg::in_word_t w, bit counted);
    feed_t f;
    f.w        = w;
    f.drain    = drain_next;
    drain_next = 1'b0;
    text_q     = {text_q, f};
    if (counted) text_count++;
  endfunction

  function automatic void put_byte(logic [7:0] b, bit counted = 1'b1);
    csvtok_pkg::in_word_t w;
    w.in_byte       = b;
    w.end_of_stream = 1'b0;
    put_word(w, counted);
  endfunction

  // in_byte rides along with the end mark and must be ignored
  function automatic void put_end(logic [7:0] junk);
    csvtok_pkg::in_word_t w;
    w.in_byte       = junk;
    w.end_of_stream = 1'b1;
    put_word(w, 1'b1);
  endfunction

  // any byte that is not a delimiter, a line break or a quote
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == csvtok_pkg::ChComma || b == csvtok_pkg::ChLf || b == csvtok_pkg::ChCr ||
           b == csvtok_pkg::ChQuote)
      b = 8'($urandom_range(255));
    return b;
  endfunction

  // bytes that steer the parser, mixed with arbitrary ones
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(5))
      0:       return csvtok_pkg::ChComma;
      1:       return csvtok_pkg::ChQuote;
      2:       return csvtok_pkg::ChCr;
      3:       return csvtok_pkg::ChLf;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void put_field();
    int len;
    logic [7:0] b;
    len = $urandom_range(6);
    if ($urandom_range(1)) begin
      // quoted: anything goes inside, quotes doubled
      put_byte(csvtok_pkg::ChQuote);
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom_range(255));
        put_byte(b);
        if (b == csvtok_pkg::ChQuote) put_byte(csvtok_pkg::ChQuote);
      end
      put_byte(csvtok_pkg::ChQuote);
    end else begin
      for (int i = 0; i < len; i++) put_byte(plain_byte());
    end
  endfunction

  function automatic void put_line_end();
    case ($urandom_range(2))
      0: put_byte(csvtok_pkg::ChLf);
      1: put_byte(csvtok_pkg::ChCr);
      default: begin
        put_byte(csvtok_pkg::ChCr);
        put_byte(csvtok_pkg::ChLf);
      end
    endcase
  endfunction

  // A run of well-formed records with an optional broken tail, then end mark.
  function automatic void put_stream();
    int nrec;
    int nfld;
    int tail;
    nrec = $urandom_range(1, 4);
    for (int r = 0; r < nrec; r++) begin
      nfld = $urandom_range(1, 4);
      for (int f = 0; f < nfld; f++) begin
        if (f != 0) put_byte(csvtok_pkg::ChComma);
        put_field();
      end
      // last record sometimes left open for the end mark to close
      if (r != nrec - 1 || $urandom_range(3) != 0) put_line_end();
    end
    tail = $urandom_range(9);
    case (tail)
      0: begin   // quote left open at end of stream
        put_byte(csvtok_pkg::ChQuote);
        for (int i = $urandom_range(3); i > 0; i--) put_byte(plain_byte());
      end
      1: begin   // quote in an unquoted field that already has content
        put_byte(plain_byte());
        put_byte(csvtok_pkg::ChQuote);
        for (int i = $urandom_range(4); i > 0; i--) put_byte(noise_byte(), 1'b0);
      end
      2: begin   // stray byte after a closing quote
        put_byte(csvtok_pkg::ChQuote);
        put_byte(plain_byte());
        put_byte(csvtok_pkg::ChQuote);
        put_byte(plain_byte());
        for (int i = $urandom_range(4); i > 0; i--) put_byte(noise_byte(), 1'b0);
      end
      default: ;
    endcase
    put_end(8'($urandom_range(255)));
  endfunction

  function automatic void put_noise();
    for (int i = $urandom_range(5, 20); i > 0; i--) begin
      if ($urandom_range(9) == 0) put_end(8'($urandom_range(255)));
      else put_byte(noise_byte());
    end
    put_end(8'($urandom_range(255)));
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers the front of text_q, keeps it stable while stalled
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit go;
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i) void'(text_q.pop_front());
        go = (text_q.size() != 0) && (calm || $urandom_range(99) >= 20);
        // a drain word waits while a word is still on the bus, then for an empty token_q
        if (go && text_q[0].drain && (in_valid_i || !drained)) go = 1'b0;
        in_valid_i <= go;
        if (go) in_data_i <= text_q[0].w;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on input accept, checks on output accept, drives stall
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    csvtok_pkg::out_word_t want;
    csvtok_pkg::out_word_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        words_in++;
        if (tokenize(in_data_i, want)) token_q = {token_q, want};
      end

      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        results_seen++;
        if (got.kind == csvtok_pkg::KIND_RECORD) records_seen++;
        if (got.kind == csvtok_pkg::KIND_ERROR) errors_seen++;
        if (token_q.size() == 0) begin
          $display("%0t: unexpected word: byte %02h kind %0d code %0d",
                   $time, got.out_byte, got.kind, got.error_code);
          mismatches++;
        end else begin
          want = token_q.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, want.out_byte, got.out_byte);
            mismatches++;
          end
          if (got.kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            mismatches++;
          end
          if (got.error_code !== want.error_code) begin
            $display("%0t: error_code expected %0d actual %0d",
                     $time, want.error_code, got.error_code);
            mismatches++;
          end
        end
      end

      // one long hold-off so the block backs up into its input
      if (results_seen == HoldAt && !held) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 20);
      end

      drained <= (token_q.size() == 0);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int streams;

    // Directed part
    put_end(8'hFF);                     // empty stream: nothing comes out
    put_byte(8'h00);
    put_byte(csvtok_pkg::ChComma);
    put_byte(csvtok_pkg::ChQuote);      // quoted field holding one literal quote
    put_byte(csvtok_pkg::ChQuote);
    put_byte(csvtok_pkg::ChQuote);
    put_byte(csvtok_pkg::ChQuote);
    put_byte(csvtok_pkg::ChComma);      // pending quote closes, then field end
    put_byte(8'hFF);
    put_byte(csvtok_pkg::ChCr);         // CR ends record
    put_byte(csvtok_pkg::ChLf);         // ...and the LF after it is swallowed
    put_byte(csvtok_pkg::ChCr);
    put_byte("b");                      // CR followed by an ordinary byte
    put_byte(csvtok_pkg::ChLf);
    put_byte(csvtok_pkg::ChQuote);      // "" then end: pending quote closes
    put_byte(csvtok_pkg::ChQuote);
    put_end(8'h00);
    put_byte("a");                      // quote inside unquoted content
    put_byte(csvtok_pkg::ChQuote);
    put_byte("c", 1'b0);                // dropped while failed
    put_end(8'h5A);
    put_byte(csvtok_pkg::ChQuote);      // byte right after a closing quote
    put_byte(csvtok_pkg::ChQuote);
    put_byte("z");
    put_end(8'hA5);
    put_byte(csvtok_pkg::ChQuote);      // quote still open at end
    put_end(8'h22);

    // Random part: mostly well-formed streams, some noise
    text_count = 0;
    streams    = 0;
    while (text_count < TextWords) begin
      streams++;
      if (streams % 25 == 0) drain_next = 1'b1;
      if ($urandom_range(7) == 0) put_noise();
      else put_stream();
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (text_q.size() != 0 || token_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (token_q.size() != 0) begin
      $display("%0t: %0d expected words never came", $time, token_q.size());
      mismatches += token_q.size();
    end

    $display("Parsed %0d text words into %0d result words, %0d record ends, %0d errors.",
             words_in, results_seen, records_seen, errors_seen);
    $display("Covered quoting, line-end styles, broken quotes, idles and back-pressure.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/csvtok_pkg.sv
rtl/csvtok_step.sv
rtl/csvtok_out_stage.sv
rtl/csv_record_tokenizer.sv
test/csv_record_tokenizer_test.sv
